// ----- design/fpam_pkg.sv -----
// Shared types and constants for the frame period average monitor.
package fpam_pkg;

	localparam int TS_W     = 32;
	localparam int ACC_W    = 33;
	localparam int RATE_W   = 20;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [RATE_W-1:0] RATE_MAX  = 20'hFFFFF;
	localparam logic [TS_W-1:0]   TPS_RESET = 32'd1000;

	// Register select taken from the word address bit.
	localparam logic REG_TPS  = 1'b0;
	localparam logic REG_LOCK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PASS,
		ST_EVAL,
		ST_DIV,
		ST_RESULT
	} fpam_state_t;

	// Decisions produced by the serial pass.
	typedef struct packed {
		logic lock_hit;
		logic near_avg;
		logic acc_over;
	} fpam_flags_t;

endpackage

// ----- design/frame_period_average_monitor_unit.sv -----
// Top level of the frame period average monitor: control, state and ports.
//
//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+------------------------------------------
//  input     | in_valid / in_stall       | timestamp
//  output    | out_valid / out_stall     | frame_accepted, elapsed_ticks, sample_stored,
//            |                           | average_ticks, frame_rate, rate_updated
//  config    | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// The priming item only records its timestamp and goes straight to ST_RESULT. A later item is
// read from the window in ST_READ, runs a bit-serial pass over SUM_W bits (32 plus the pointer
// width) in ST_PASS and is judged in ST_EVAL; a stored period adds a restoring division in ST_DIV.
// Each result is loaded into the output register from ST_RESULT once that register is free.
// Reset clears control state, counters and the average but not the window memory, whose entries
// are read only once it is full. The next item is accepted once a result sits in the output
// register, even under stall; the following result then waits until that register is free.
module frame_period_average_monitor_unit #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [fpam_pkg::TS_W-1:0]            timestamp,
	// Output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 frame_accepted,
	output logic [fpam_pkg::TS_W-1:0]            elapsed_ticks,
	output logic                                 sample_stored,
	output logic [fpam_pkg::TS_W-1:0]            average_ticks,
	output logic [fpam_pkg::RATE_W-1:0]          frame_rate,
	output logic                                 rate_updated,
	// Configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fpam_pkg::ADDR_W-1:0]          paddr,
	input  logic [fpam_pkg::DATA_W-1:0]          pwdata,
	output logic [fpam_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);

	localparam int TS_W  = fpam_pkg::TS_W;
	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = TS_W + PTR_W;

	fpam_pkg::fpam_state_t state_q, state_d;

	// Configuration registers.
	logic [TS_W-1:0] tps_q, lock_q;

	// Monitor state.
	logic                          primed_q;
	logic [TS_W-1:0]               last_time_q;
	logic [TS_W-1:0]               ts_q;
	logic [CNT_W-1:0]              count_q;
	logic [PTR_W-1:0]              ptr_q;
	logic [SUM_W-1:0]              sum_q;
	logic [TS_W-1:0]               avg_q;
	logic [fpam_pkg::RATE_W-1:0]   frames_q;
	logic [fpam_pkg::ACC_W-1:0]    acc_q;
	logic [fpam_pkg::RATE_W-1:0]   rate_q;

	// Result waiting for the output register.
	logic            res_accepted_q, res_stored_q, res_updated_q;
	logic [TS_W-1:0] res_el_q;

	// Control strobes.
	logic in_accept, cfg_write, ram_re, ram_we, alu_start, div_start, out_load;
	logic full, store;

	logic [TS_W-1:0]               ram_rdata, old_val;
	logic                          alu_done, div_done;
	logic [TS_W-1:0]               alu_el;
	logic [fpam_pkg::ACC_W-1:0]    alu_acc_new;
	logic [SUM_W-1:0]              alu_sum_new, quotient;
	fpam_pkg::fpam_flags_t         alu_flags;
	logic [CNT_W-1:0]              count_next;
	logic [fpam_pkg::RATE_W-1:0]   frames_next;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign prdata    = (paddr[2] == fpam_pkg::REG_LOCK) ? lock_q : tps_q;

	assign in_accept = in_valid & ~in_stall;
	assign full      = count_q == CNT_W'(WINDOW_DEPTH);
	assign old_val   = full ? ram_rdata : '0;
	assign store     = ~alu_flags.lock_hit & alu_flags.near_avg;
	assign count_next  = full ? count_q : count_q + 1'b1;
	assign frames_next = (frames_q == fpam_pkg::RATE_MAX) ? frames_q : frames_q + 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fpam_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = primed_q ? fpam_pkg::ST_READ : fpam_pkg::ST_RESULT;
				end
			end
			fpam_pkg::ST_READ: begin
				state_d = fpam_pkg::ST_PASS;
			end
			fpam_pkg::ST_PASS: begin
				if (alu_done) begin
					state_d = fpam_pkg::ST_EVAL;
				end
			end
			fpam_pkg::ST_EVAL: begin
				state_d = store ? fpam_pkg::ST_DIV : fpam_pkg::ST_RESULT;
			end
			fpam_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = fpam_pkg::ST_RESULT;
				end
			end
			fpam_pkg::ST_RESULT: begin
				if (!out_valid || !out_stall) begin
					state_d = fpam_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fpam_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_stall  = 1'b1;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		alu_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			fpam_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				ram_re   = in_valid;
			end
			fpam_pkg::ST_READ: begin
				alu_start = 1'b1;
			end
			fpam_pkg::ST_EVAL: begin
				ram_we    = store;
				div_start = store;
			end
			fpam_pkg::ST_RESULT: begin
				out_load = ~out_valid | ~out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpam_pkg::ST_IDLE;
			tps_q   <= fpam_pkg::TPS_RESET;
			lock_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				if (paddr[2] == fpam_pkg::REG_LOCK) begin
					lock_q <= pwdata;
				end else begin
					tps_q <= pwdata;
				end
			end
		end
	end

	// Monitor state. The priming item records its timestamp at acceptance; an accepted frame
	// updates the rate counters, and the window if stored, once the serial pass has finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q    <= 1'b0;
			last_time_q <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			frames_q    <= '0;
			acc_q       <= '0;
			rate_q      <= '0;
		end else begin
			if (in_accept && !primed_q) begin
				primed_q    <= 1'b1;
				last_time_q <= timestamp;
			end
			if (state_q == fpam_pkg::ST_EVAL && !alu_flags.lock_hit) begin
				last_time_q <= ts_q;
				if (alu_flags.near_avg) begin
					sum_q   <= alu_sum_new;
					count_q <= count_next;
					ptr_q   <= (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				end
				if (alu_flags.acc_over) begin
					rate_q   <= frames_next;
					frames_q <= '0;
					acc_q    <= '0;
				end else begin
					frames_q <= frames_next;
					acc_q    <= alu_acc_new;
				end
			end
			if (div_done) begin
				avg_q <= quotient[TS_W-1:0];
			end
		end
	end

	// Item payload and the result flags for it.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ts_q           <= timestamp;
			res_el_q       <= '0;
			res_accepted_q <= 1'b0;
			res_stored_q   <= 1'b0;
			res_updated_q  <= 1'b0;
		end
		if (state_q == fpam_pkg::ST_EVAL) begin
			res_el_q       <= alu_el;
			res_accepted_q <= ~alu_flags.lock_hit;
			res_stored_q   <= store;
			res_updated_q  <= ~alu_flags.lock_hit & alu_flags.acc_over;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			frame_accepted <= res_accepted_q;
			elapsed_ticks  <= res_el_q;
			sample_stored  <= res_stored_q;
			average_ticks  <= avg_q;
			frame_rate     <= rate_q;
			rate_updated   <= res_updated_q;
		end
	end

	fpam_ram #(
		.DEPTH (WINDOW_DEPTH),
		.PTR_W (PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (alu_el),
		.re    (ram_re),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	fpam_alu #(
		.SUM_W (SUM_W)
	) u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (alu_start),
		.ts      (ts_q),
		.last    (last_time_q),
		.lock    (lock_q),
		.avg     (avg_q),
		.tps     (tps_q),
		.acc     (acc_q),
		.sum     (sum_q),
		.old     (old_val),
		.done    (alu_done),
		.el      (alu_el),
		.acc_new (alu_acc_new),
		.sum_new (alu_sum_new),
		.flags   (alu_flags)
	);

	fpam_div #(
		.N_W (SUM_W),
		.D_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (alu_sum_new),
		.divisor  (count_next),
		.done     (div_done),
		.quotient (quotient)
	);

endmodule

// ----- design/fpam_ram.sv -----
// Period window storage with one write port and a registered read port.
module fpam_ram #(
	parameter int DEPTH = 32,
	parameter int PTR_W = 5
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [PTR_W-1:0]          waddr,
	input  logic [fpam_pkg::TS_W-1:0] wdata,
	input  logic                      re,
	input  logic [PTR_W-1:0]          raddr,
	output logic [fpam_pkg::TS_W-1:0] rdata
);

	logic [fpam_pkg::TS_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/fpam_alu.sv -----
// Bit-serial pass: elapsed time, lock and outlier compares, accumulator and window sum.
module fpam_alu #(
	parameter int SUM_W = 37
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fpam_pkg::TS_W-1:0]   ts,
	input  logic [fpam_pkg::TS_W-1:0]   last,
	input  logic [fpam_pkg::TS_W-1:0]   lock,
	input  logic [fpam_pkg::TS_W-1:0]   avg,
	input  logic [fpam_pkg::TS_W-1:0]   tps,
	input  logic [fpam_pkg::ACC_W-1:0]  acc,
	input  logic [SUM_W-1:0]            sum,
	input  logic [fpam_pkg::TS_W-1:0]   old,
	output logic                        done,
	output logic [fpam_pkg::TS_W-1:0]   el,
	output logic [fpam_pkg::ACC_W-1:0]  acc_new,
	output logic [SUM_W-1:0]            sum_new,
	output fpam_pkg::fpam_flags_t       flags
);

	localparam int DW    = fpam_pkg::TS_W;
	localparam int AW    = fpam_pkg::ACC_W;
	localparam int CNT_W = $clog2(SUM_W);

	logic             run_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    ts_q, last_q, lock_q, avg_q, tps_q, old_q;
	logic [AW-1:0]    acc_q;
	logic [SUM_W-1:0] sum_q;
	logic [DW-1:0]    el_q;
	logic [AW-1:0]    accn_q;
	logic [SUM_W-1:0] sumn_q;
	logic             br_el_q, br1_q, br2_q, ca_q, cs_q, bs_q;
	logic             lt_lock_q, lnz_q, lt1_q, lt2_q, gt_q;

	logic low, in_acc;
	logic e_raw, e, br_el_n;
	logic d1, d2, br1_n, br2_n;
	logic x, ca_n;
	logic s1, cs_n, s2, bs_n;

	always_comb begin
		low     = cnt_q < CNT_W'(DW);
		in_acc  = cnt_q < CNT_W'(AW);
		e_raw   = ts_q[0] ^ last_q[0] ^ br_el_q;
		br_el_n = (~ts_q[0] & last_q[0]) | (~(ts_q[0] ^ last_q[0]) & br_el_q);
		e       = low & e_raw;
		d1      = e ^ avg_q[0] ^ br1_q;
		br1_n   = (~e & avg_q[0]) | (~(e ^ avg_q[0]) & br1_q);
		d2      = avg_q[0] ^ e ^ br2_q;
		br2_n   = (~avg_q[0] & e) | (~(avg_q[0] ^ e) & br2_q);
		x       = acc_q[0] ^ e ^ ca_q;
		ca_n    = (acc_q[0] & e) | (ca_q & (acc_q[0] ^ e));
		s1      = sum_q[0] ^ e ^ cs_q;
		cs_n    = (sum_q[0] & e) | (cs_q & (sum_q[0] ^ e));
		s2      = s1 ^ old_q[0] ^ bs_q;
		bs_n    = (~s1 & old_q[0]) | (~(s1 ^ old_q[0]) & bs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ts_q      <= ts;
			last_q    <= last;
			lock_q    <= lock;
			avg_q     <= avg;
			tps_q     <= tps;
			old_q     <= old;
			acc_q     <= acc;
			sum_q     <= sum;
			br_el_q   <= 1'b0;
			br1_q     <= 1'b0;
			br2_q     <= 1'b0;
			ca_q      <= 1'b0;
			cs_q      <= 1'b0;
			bs_q      <= 1'b0;
			lt_lock_q <= 1'b0;
			lnz_q     <= 1'b0;
			lt1_q     <= 1'b0;
			lt2_q     <= 1'b0;
			gt_q      <= 1'b0;
		end else if (run_q) begin
			ts_q   <= {1'b0, ts_q[DW-1:1]};
			last_q <= {1'b0, last_q[DW-1:1]};
			lock_q <= {1'b0, lock_q[DW-1:1]};
			avg_q  <= {1'b0, avg_q[DW-1:1]};
			tps_q  <= {1'b0, tps_q[DW-1:1]};
			old_q  <= {1'b0, old_q[DW-1:1]};
			acc_q  <= {1'b0, acc_q[AW-1:1]};
			sum_q  <= {1'b0, sum_q[SUM_W-1:1]};
			sumn_q <= {s2, sumn_q[SUM_W-1:1]};
			cs_q   <= cs_n;
			bs_q   <= bs_n;
			if (low) begin
				el_q    <= {e, el_q[DW-1:1]};
				br_el_q <= br_el_n;
				br1_q   <= br1_n;
				br2_q   <= br2_n;
				lnz_q   <= lnz_q | lock_q[0];
				if (e != lock_q[0]) begin
					lt_lock_q <= lock_q[0];
				end
				if (d1 != tps_q[0]) begin
					lt1_q <= tps_q[0];
				end
				if (d2 != tps_q[0]) begin
					lt2_q <= tps_q[0];
				end
			end
			if (in_acc) begin
				accn_q <= {x, accn_q[AW-1:1]};
				ca_q   <= ca_n;
				if (x != tps_q[0]) begin
					gt_q <= x;
				end
			end
		end
	end

	assign done           = done_q;
	assign el             = el_q;
	assign acc_new        = accn_q;
	assign sum_new        = sumn_q;
	assign flags.lock_hit = lnz_q & lt_lock_q;
	assign flags.near_avg = br1_q ? lt2_q : lt1_q;
	assign flags.acc_over = gt_q;

endmodule

// ----- design/fpam_div.sv -----
// Restoring divider, one quotient bit per cycle.
module fpam_div #(
	parameter int N_W = 37,
	parameter int D_W = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W);

	logic             run_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   qd_q;
	logic [D_W-1:0]   rem_q, div_q;
	logic [D_W:0]     r2, diff;
	logic             ge;

	always_comb begin
		r2   = {rem_q, qd_q[N_W-1]};
		diff = r2 - {1'b0, div_q};
		ge   = r2 >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNT_W'(N_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			qd_q  <= {qd_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : r2[D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = qd_q;

endmodule

// ----- design/fpam_checker.sv -----
// Port-level checks for the frame period average monitor, bound to the top level.
module fpam_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              frame_accepted,
	input logic [fpam_pkg::TS_W-1:0]         elapsed_ticks,
	input logic                              sample_stored,
	input logic                              rate_updated
);

	// A result held under stall keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(elapsed_ticks))
		else $error("output item changed while stalled");

	// Only an accepted frame can enter the window.
	a_stored_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_stored |-> frame_accepted)
		else $error("sample stored without an accepted frame");

	// Only an accepted frame can close a rate window.
	a_rate_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rate_updated |-> frame_accepted)
		else $error("rate updated without an accepted frame");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted straight after the first");

endmodule

bind frame_period_average_monitor_unit fpam_checker u_fpam_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.frame_accepted (frame_accepted),
	.elapsed_ticks  (elapsed_ticks),
	.sample_stored  (sample_stored),
	.rate_updated   (rate_updated)
);
